FILE: rtl/bis_pkg.sv
// Shared types and constants for the bounded integer set.
package bis_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CountW = 5;

  typedef enum logic [KindW-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_TEST   = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [WordW-1:0] value;
  } cell_cmd_t;

endpackage

FILE: rtl/bis_if.sv
// Valid/ready channel interfaces for the operation and result words.
interface bis_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface bis_out_if;
  logic        valid;
  logic        ready;
  logic        done_res;
  logic        was_present;
  logic [4:0]  count;
  logic        has_bounds;
  logic signed [31:0] largest;
  logic signed [31:0] smallest;

  modport source (output valid, output done_res, output was_present, output count,
                  output has_bounds, output largest, output smallest, input ready);
  modport sink   (input valid, input done_res, input was_present, input count,
                  input has_bounds, input largest, input smallest, output ready);
endinterface

FILE: rtl/bis_cell.sv
// One cell of the sorted member row: holds one member, shifts with its neighbors.
module bis_cell #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                     clk_i,
  input  bis_pkg::cell_cmd_t       cmd_i,
  input  logic [CntW-1:0]          count_i,
  input  logic                     left_after_i,
  input  logic [bis_pkg::WordW-1:0] left_data_i,
  input  logic [bis_pkg::WordW-1:0] right_data_i,
  output logic                     after_o,
  output logic                     hit_o,
  output logic [bis_pkg::WordW-1:0] data_o
);
  import bis_pkg::*;

  logic [WordW-1:0] data_q, data_d;
  logic             valid;
  logic             gt;

  assign valid = count_i > CntW'(Idx);
  assign gt    = $signed(data_q) > $signed(cmd_i.value);
  assign hit_o = valid && (data_q == cmd_i.value);
  // Empty cells sit after every member.
  assign after_o = !valid || gt;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins && after_o) begin
      data_d = left_after_i ? left_data_i : cmd_i.value;
    end else if (cmd_i.rem && valid && (gt || hit_o)) begin
      // close the gap: take the right neighbor
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: rtl/bounded_integer_set.sv
// Bounded integer set: top level with control, row of cells and result register.
//
// Operation words arrive on in_i (kind, value) and result words leave on out_o.
// kind selects clear, insert, membership test or remove. Members are kept in
// ascending order in a row of SetCapacity cells; on insert or remove each
// cell takes its own, its left or its right neighbor's member or the new value,
// so the smallest member is in the first cell and the largest at count - 1.
// Membership is a broadcast compare across all cells, reduced by one OR.
// A word accepted in ST_IDLE updates the row and count in ST_EXEC; its result
// is loaded into the result register in ST_LOAD once that register is free.
// A new word can be taken in ST_LOAD as the last result loads, after the row
// update and the bounds read of the updated row.
// The result register holds its word while out_o.ready is low; in_i.ready is
// high in ST_IDLE, else low until that register can take the next result.
// Reset empties the set (count zero) and clears the output valid; member
// contents are not cleared and are never read beyond the count.
module bounded_integer_set #(
  parameter int unsigned SetCapacity = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bis_in_if.sink    in_i,
  bis_out_if.source out_o
);
  import bis_pkg::*;

  localparam int unsigned CntW = $clog2(SetCapacity + 1);
  localparam int unsigned IdxW = (SetCapacity > 1) ? $clog2(SetCapacity) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_e;

  state_e            state_q;
  kind_e             kind_q;
  logic [WordW-1:0]  value_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              done_q, done_d;
  logic              pres_q, pres_d;

  logic              out_valid_q;
  logic              out_done_q, out_pres_q, out_bounds_q;
  logic [CountW-1:0] out_count_q;
  logic [WordW-1:0]  out_large_q, out_small_q;

  logic              out_free, in_fire;
  logic              present, full;
  cell_cmd_t         cmd;

  logic [WordW-1:0]  cell_data [SetCapacity];
  logic              cell_after [SetCapacity];
  logic [SetCapacity-1:0] hit_vec;

  logic [CntW-1:0]   last_cnt;
  logic [CntW+CountW-1:0] cnt_pad;

  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) || (state_q == ST_LOAD && out_free);
  assign in_fire = in_i.valid && in_i.ready;

  assign present = |hit_vec;
  assign full    = count_q == CntW'(SetCapacity);

  always_comb begin
    cmd.value = value_q;
    cmd.ins   = (state_q == ST_EXEC) && (kind_q == KIND_INSERT) && !present && !full;
    cmd.rem   = (state_q == ST_EXEC) && (kind_q == KIND_REMOVE) && present;
  end

  always_comb begin
    count_d = count_q;
    done_d  = 1'b0;
    pres_d  = present;
    case (kind_q)
      KIND_CLEAR: begin
        count_d = '0;
        done_d  = 1'b1;
        pres_d  = 1'b0;
      end
      KIND_INSERT: begin
        done_d = cmd.ins;
        if (cmd.ins) count_d = count_q + 1'b1;
      end
      KIND_TEST: begin
        done_d = present;
      end
      KIND_REMOVE: begin
        done_d = cmd.rem;
        if (cmd.rem) count_d = count_q - 1'b1;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < SetCapacity; i++) begin : g_cell
    logic             left_after;
    logic [WordW-1:0] left_data, right_data;
    if (i == 0) begin : g_first
      assign left_after = 1'b0;
      assign left_data  = value_q;
    end else begin : g_mid
      assign left_after = cell_after[i-1];
      assign left_data  = cell_data[i-1];
    end
    if (i == SetCapacity - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end
    bis_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .count_i      (count_q),
      .left_after_i (left_after),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .after_o      (cell_after[i]),
      .hit_o        (hit_vec[i]),
      .data_o       (cell_data[i])
    );
  end

  assign last_cnt = count_q - 1'b1;
  assign cnt_pad  = {{CountW{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // load a new result word, else drop the one just taken
      if (state_q == ST_LOAD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          count_q <= count_d;
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            state_q <= in_fire ? ST_EXEC : ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_e'(in_i.kind);
      value_q <= in_i.value;
    end
    if (state_q == ST_EXEC) begin
      done_q <= done_d;
      pres_q <= pres_d;
    end
    if (state_q == ST_LOAD && out_free) begin
      out_done_q   <= done_q;
      out_pres_q   <= pres_q;
      out_count_q  <= cnt_pad[CountW-1:0];
      out_bounds_q <= count_q != '0;
      out_large_q  <= (count_q != '0) ? cell_data[last_cnt[IdxW-1:0]] : '0;
      out_small_q  <= (count_q != '0) ? cell_data[0] : '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.done_res    = out_done_q;
  assign out_o.was_present = out_pres_q;
  assign out_o.count       = out_count_q;
  assign out_o.has_bounds  = out_bounds_q;
  assign out_o.largest     = out_large_q;
  assign out_o.smallest    = out_small_q;

endmodule

FILE: verif/tb_bounded_integer_set.sv
// Testbench for the bounded integer set: a directed table then random operation words, scored against a set predictor.
`timescale 1ns / 100ps

module tb_bounded_integer_set;
  import bis_pkg::*;

  localparam int SetCap      = 16;
  localparam int RandomWords = 1750;
  localparam int PoolSize    = 24;

  typedef struct packed {
    logic              done_res;
    logic              was_present;
    logic [CountW-1:0] count;
    logic              has_bounds;
    logic [WordW-1:0]  largest;
    logic [WordW-1:0]  smallest;
  } set_result_t;

  typedef struct {
    kind_e            kind;
    logic [WordW-1:0] value;
    bit               typed;
    set_result_t      result;
  } op_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bis_in_if  op_if ();
  bis_out_if res_if ();

  bounded_integer_set #(.SetCapacity(SetCap)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_if),
    .out_o (res_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted set contents; storage order does not matter.
  logic signed [WordW-1:0] set_members [SetCap];
  int                      set_size = 0;
  set_result_t             pending_results [$];
  int                      err_count = 0;
  int                      burst_left = 0;
  logic signed [WordW-1:0] value_pool [PoolSize];

  // Rows with a typed result hold the expectation; the rest go through the predictor.
  op_row_t dir_rows [26] = '{
    '{KIND_TEST,   32'h0000_0000, 1'b1, '{1'b0, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0}},
    '{KIND_REMOVE, 32'h8000_0000, 1'b1, '{1'b0, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0}},
    '{KIND_INSERT, 32'h7fff_ffff, 1'b1,
      '{1'b1, 1'b0, 5'd1, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff}},
    '{KIND_INSERT, 32'h8000_0000, 1'b1,
      '{1'b1, 1'b0, 5'd2, 1'b1, 32'h7fff_ffff, 32'h8000_0000}},
    '{KIND_INSERT, 32'h7fff_ffff, 1'b1,
      '{1'b0, 1'b1, 5'd2, 1'b1, 32'h7fff_ffff, 32'h8000_0000}},
    '{KIND_TEST,   32'h8000_0000, 1'b1,
      '{1'b1, 1'b1, 5'd2, 1'b1, 32'h7fff_ffff, 32'h8000_0000}},
    '{KIND_REMOVE, 32'h7fff_ffff, 1'b1,
      '{1'b1, 1'b1, 5'd1, 1'b1, 32'h8000_0000, 32'h8000_0000}},
    '{KIND_CLEAR,  32'hffff_ffff, 1'b1, '{1'b1, 1'b0, 5'd0, 1'b0, 32'h0, 32'h0}},
    // fill to capacity
    '{KIND_INSERT, 32'h0000_0000, 1'b0, '0},
    '{KIND_INSERT, 32'hffff_ffff, 1'b0, '0},
    '{KIND_INSERT, 32'h0000_0001, 1'b0, '0},
    '{KIND_INSERT, 32'h7fff_ffff, 1'b0, '0},
    '{KIND_INSERT, 32'h8000_0000, 1'b0, '0},
    '{KIND_INSERT, 32'h8000_0001, 1'b0, '0},
    '{KIND_INSERT, 32'h7fff_fffe, 1'b0, '0},
    '{KIND_INSERT, 32'h5555_5555, 1'b0, '0},
    '{KIND_INSERT, 32'haaaa_aaaa, 1'b0, '0},
    '{KIND_INSERT, 32'h0000_ffff, 1'b0, '0},
    '{KIND_INSERT, 32'hffff_0000, 1'b0, '0},
    '{KIND_INSERT, 32'h1234_5678, 1'b0, '0},
    '{KIND_INSERT, 32'hedcb_a987, 1'b0, '0},
    '{KIND_INSERT, 32'h0000_0100, 1'b0, '0},
    '{KIND_INSERT, 32'hffff_ff00, 1'b0, '0},
    '{KIND_INSERT, 32'h0f0f_0f0f, 1'b0, '0},
    // full: refuse a new value, then drop the smallest
    '{KIND_INSERT, 32'h0000_0002, 1'b0, '0},
    '{KIND_REMOVE, 32'h8000_0000, 1'b0, '0}
  };

  function automatic set_result_t apply_set_op(kind_e kind, logic signed [WordW-1:0] value);
    set_result_t             r;
    int                      pos;
    logic                    found;
    logic signed [WordW-1:0] hi;
    logic signed [WordW-1:0] lo;
    r     = '0;
    pos   = set_size;
    found = 1'b0;
    for (int i = 0; i < set_size; i++) begin
      if (!found && set_members[i] == value) begin
        pos   = i;
        found = 1'b1;
      end
    end
    r.was_present = found;
    case (kind)
      KIND_CLEAR: begin
        set_size      = 0;
        r.was_present = 1'b0;
        r.done_res    = 1'b1;
      end
      KIND_INSERT: begin
        if (!found && set_size < SetCap) begin
          set_members[set_size] = value;
          set_size++;
          r.done_res = 1'b1;
        end
      end
      KIND_TEST: begin
        r.done_res = found;
      end
      default: begin
        if (found) begin
          set_members[pos] = set_members[set_size-1];
          set_size--;
          r.done_res = 1'b1;
        end
      end
    endcase
    r.count      = CountW'(set_size);
    r.has_bounds = (set_size != 0);
    if (set_size != 0) begin
      hi = set_members[0];
      lo = set_members[0];
      for (int i = 1; i < set_size; i++) begin
        if (set_members[i] > hi) hi = set_members[i];
        if (set_members[i] < lo) lo = set_members[i];
      end
      r.largest  = hi;
      r.smallest = lo;
    end
    return r;
  endfunction

  // Called at a falling edge; returns at a falling edge after the word is taken.
  task automatic send_op(kind_e kind, logic [WordW-1:0] value, bit typed,
                         set_result_t typed_res);
    set_result_t predicted;
    op_if.valid <= 1'b1;
    op_if.kind  <= kind;
    op_if.value <= value;
    do @(posedge clk_i); while (op_if.ready !== 1'b1);
    predicted = apply_set_op(kind, value);
    pending_results.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // drop valid and put noise on the payload for the gap
      op_if.valid <= 1'b0;
      op_if.kind  <= 2'($urandom);
      op_if.value <= $urandom;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 24 : 4)) @(negedge clk_i);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  initial begin
    kind_e            kind;
    logic [WordW-1:0] value;
    int               mode;
    int               mode_left;
    int               pick;
    int               clr_lim;
    int               ins_lim;
    int               tst_lim;
    op_if.valid = 1'b0;
    op_if.kind  = '0;
    op_if.value = '0;
    mode_left   = 0;
    mode        = 0;
    foreach (value_pool[i]) begin
      value_pool[i] = (i < 6) ? WordW'($signed(i) - 3) : $urandom;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].result);
    end

    for (int n = 0; n < RandomWords; n++) begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 120);
      end
      mode_left--;
      // grow, shrink or churn the set
      case (mode)
        0:       begin clr_lim = 1; ins_lim = 66; tst_lim = 81; end
        1:       begin clr_lim = 2; ins_lim = 22; tst_lim = 42; end
        default: begin clr_lim = 4; ins_lim = 44; tst_lim = 72; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < clr_lim)      kind = KIND_CLEAR;
      else if (pick < ins_lim) kind = KIND_INSERT;
      else if (pick < tst_lim) kind = KIND_TEST;
      else                     kind = KIND_REMOVE;

      pick = $urandom_range(0, 99);
      if (pick < 45 && set_size > 0) begin
        value = set_members[$urandom_range(0, set_size - 1)];
      end else if (pick < 75) begin
        value = value_pool[$urandom_range(0, PoolSize - 1)];
      end else if (pick < 92) begin
        value = $urandom;
      end else begin
        case ($urandom_range(0, 3))
          0:       value = 32'h8000_0000;
          1:       value = 32'h7fff_ffff;
          2:       value = 32'hffff_ffff;
          default: value = 32'h0000_0000;
        endcase
      end
      send_op(kind, value, 1'b0, '0);
    end
    op_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: switch at random between always ready, a rotating stall pattern and random stalls.
  initial begin
    int          stall_mode;
    logic [15:0] pattern;
    res_if.ready = 1'b0;
    forever begin
      stall_mode = $urandom_range(0, 2);
      pattern    = 16'($urandom) | 16'h0001;
      repeat ($urandom_range(20, 200)) begin
        @(negedge clk_i);
        case (stall_mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= pattern[0];
          default: res_if.ready <= ($urandom_range(0, 9) < 6);
        endcase
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no pending expectation");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_if.done_res !== want.done_res) begin
          $error("done_res: expected %0d, actual %0d", want.done_res, res_if.done_res);
          err_count++;
        end
        if (res_if.was_present !== want.was_present) begin
          $error("was_present: expected %0d, actual %0d", want.was_present, res_if.was_present);
          err_count++;
        end
        if (res_if.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, res_if.count);
          err_count++;
        end
        if (res_if.has_bounds !== want.has_bounds) begin
          $error("has_bounds: expected %0d, actual %0d", want.has_bounds, res_if.has_bounds);
          err_count++;
        end
        if (res_if.largest !== want.largest) begin
          $error("largest: expected %0d, actual %0d", $signed(want.largest), res_if.largest);
          err_count++;
        end
        if (res_if.smallest !== want.smallest) begin
          $error("smallest: expected %0d, actual %0d", $signed(want.smallest), res_if.smallest);
          err_count++;
        end
      end
    end
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
